FILE: hw/rtl/led_strip_pattern_channel_store_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the lighting channel store
// Each macro expands to a labeled concurrent assertion, or to nothing when
// ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef LED_STRIP_PATTERN_CHANNEL_STORE_CORE_DEFINES_SVH
`define LED_STRIP_PATTERN_CHANNEL_STORE_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a same-cycle implication
`define LSPCS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lspcs assertion failed");
// Check an implication in the next cycle
`define LSPCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lspcs assertion failed");
`else
`define LSPCS_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define LSPCS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: hw/rtl/lspcs_pkg.sv
// ----------------------------------------------------------------------------
// lspcs_pkg
// Shared types, constants and helpers of the lighting channel store.
// ----------------------------------------------------------------------------
package lspcs_pkg;

   // Store geometry and field widths
   localparam int NUM_CHANNELS_DEF = 512;
   localparam int IDX_W            = 10;
   localparam int STEP_W           = 10;
   localparam int LED_W            = 8;
   localparam int BYTE_W           = 8;
   localparam int MODE_W           = 3;
   localparam int APB_DATA_W       = 32;
   localparam int APB_ADDR_W       = 3;

   // Remainder unit: one dividend bit per cycle
   localparam int DIV_STEPS = STEP_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // Animation constants
   localparam logic [STEP_W-1:0] STEP_LAST     = STEP_W'(999);
   localparam logic [LED_W-1:0]  RED_PERIOD    = LED_W'(5);
   localparam logic [LED_W-1:0]  RED_ON        = LED_W'(3);
   localparam logic [LED_W-1:0]  YELLOW_PERIOD = LED_W'(30);
   localparam logic [LED_W-1:0]  YELLOW_ON     = LED_W'(15);
   localparam logic [IDX_W-1:0]  BLUE_SPAN     = IDX_W'(5);
   localparam logic [BYTE_W-1:0] RED_LEVEL     = BYTE_W'(255);
   localparam logic [BYTE_W-1:0] YELLOW_LEVEL  = BYTE_W'(200);
   localparam logic [BYTE_W-1:0] WHITE_LEVEL   = BYTE_W'(220);
   localparam logic [LED_W-1:0]  LED_COUNT_RST = LED_W'(60);

   // Lighting modes
   localparam logic [MODE_W-1:0] MODE_DARK   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_BLUE   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_RED    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_YELLOW = 3'd3;
   localparam logic [MODE_W-1:0] MODE_WHITE  = 3'd4;

   // Color slot inside one LED's four channels
   localparam logic [1:0] COLOR_RED   = 2'd0;
   localparam logic [1:0] COLOR_GREEN = 2'd1;
   localparam logic [1:0] COLOR_BLUE  = 2'd2;
   localparam logic [1:0] COLOR_WHITE = 2'd3;

   // Register index (paddr word bits)
   localparam logic [APB_ADDR_W-3:0] REG_LED_COUNT = '0;

   typedef enum logic [1:0] {
      OP_TICK,
      OP_SET_MODE,
      OP_WRITE,
      OP_READ
   } opcode_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_SWEEP,
      ST_READ,
      ST_DONE
   } seq_state_type;

   // Remainder unit request and status
   typedef struct packed {
      logic              start;
      logic [STEP_W-1:0] dividend;
      logic [LED_W-1:0]  divisor;
   } rem_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [LED_W-1:0] remainder;
   } rem_rsp_type;

   // Blue level by distance from the active LED
   function automatic logic [BYTE_W-1:0] blue_fade(input logic [2:0] gap);
      logic [BYTE_W-1:0] level;
      unique case (gap)
         3'd0:    level = BYTE_W'(255);
         3'd1:    level = BYTE_W'(204);
         3'd2:    level = BYTE_W'(153);
         3'd3:    level = BYTE_W'(102);
         3'd4:    level = BYTE_W'(50);
         default: level = '0;
      endcase
      return level;
   endfunction

endpackage

FILE: hw/rtl/lspcs_ifs.sv
// ----------------------------------------------------------------------------
// lspcs_ifs
// Request and response channels of the lighting channel store.
// ----------------------------------------------------------------------------
interface lspcs_req_if;
   import lspcs_pkg::*;

   logic              valid;
   logic              ready;
   logic [1:0]        opcode;
   logic [MODE_W-1:0] mode_code;
   logic [IDX_W-1:0]  channel_number;
   logic [BYTE_W-1:0] channel_value;

   modport source (output valid, opcode, mode_code, channel_number, channel_value,
                   input ready);
   modport sink   (input valid, opcode, mode_code, channel_number, channel_value,
                   output ready);
endinterface

interface lspcs_rsp_if;
   import lspcs_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] read_value;
   logic              bad_request;
   logic [MODE_W-1:0] mode_now;
   logic [STEP_W-1:0] step_now;

   modport source (output valid, read_value, bad_request, mode_now, step_now,
                   input ready);
   modport sink   (input valid, read_value, bad_request, mode_now, step_now,
                   output ready);
endinterface

FILE: hw/rtl/led_strip_pattern_channel_store_core.sv
// ----------------------------------------------------------------------------
// led_strip_pattern_channel_store_core
// Lighting channel store with mode, animation step and pattern painter.
//
//   port      direction  handshake           carries
//   req_chan  in         valid/ready         opcode, mode, channel, value
//   rsp_chan  out        valid/ready         read value, flag, mode, step
//   p*        in/out     APB, pready high    LED count register
//
// Tick: the remainder unit runs, then one channel is written per cycle
// through the single RAM port. Set mode and write go from idle straight to
// done; read passes through a read state first (registered RAM read).
// After reset a clearing pass writes zero to every channel, with req_chan.ready
// low. One word is handled at a time; a finished word waits in the
// response register while the next one is accepted.
// ----------------------------------------------------------------------------
`include "led_strip_pattern_channel_store_core_defines.svh"

module led_strip_pattern_channel_store_core #(
   parameter int NUM_CHANNELS = lspcs_pkg::NUM_CHANNELS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   lspcs_req_if.sink                             req_chan,
   lspcs_rsp_if.source                           rsp_chan,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [lspcs_pkg::APB_ADDR_W-1:0]      paddr,
   input  logic [lspcs_pkg::APB_DATA_W-1:0]      pwdata,
   output logic [lspcs_pkg::APB_DATA_W-1:0]      prdata,
   output logic                                  pready
);
   import lspcs_pkg::*;

   localparam int AW = $clog2(NUM_CHANNELS);
   localparam logic [AW-1:0] ADDR_LAST = AW'(NUM_CHANNELS - 1);

   seq_state_type     state_ff, state_in;
   opcode_type        op_ff, op_in;
   logic [MODE_W-1:0] code_ff, code_in;
   logic [IDX_W-1:0]  ch_ff, ch_in;
   logic [BYTE_W-1:0] val_ff, val_in;
   logic [AW-1:0]     addr_ff, addr_in;
   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [STEP_W-1:0] step_ff, step_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] read_value_ff, read_value_in;
   logic              bad_ff, bad_in;
   logic [MODE_W-1:0] mode_now_ff;
   logic [STEP_W-1:0] step_now_ff;

   logic [LED_W-1:0]  led_count;
   rem_req_type       rem_req;
   rem_rsp_type       rem_rsp;

   logic              accept;
   logic              finish;
   logic              slot_free;
   logic              ch_ok;
   logic [IDX_W-1:0]  ch_idx;
   logic [AW-1:0]     ch_addr;

   logic              ram_we;
   logic              ram_re;
   logic [AW-1:0]     ram_addr;
   logic [BYTE_W-1:0] ram_wdata;
   logic [BYTE_W-1:0] ram_rdata;

   logic [IDX_W-1:0]  pix_led;
   logic [1:0]        pix_color;
   logic [IDX_W-1:0]  active;
   logic [IDX_W-1:0]  led_gap;
   logic              in_strip;
   logic [BYTE_W-1:0] pix_value;

   // Register and shared remainder unit
   lspcs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .led_count (led_count)
   );

   lspcs_rem u_rem (
      .clock (clock),
      .reset (reset),
      .req   (rem_req),
      .rsp   (rem_rsp)
   );

   lspcs_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (NUM_CHANNELS)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .re    (ram_re),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign accept    = req_chan.valid && req_chan.ready;
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;

   // Decode the one-based channel
   assign ch_ok   = (ch_ff != '0) && (ch_ff <= IDX_W'(NUM_CHANNELS));
   assign ch_idx  = ch_ff - IDX_W'(1);
   assign ch_addr = ch_idx[AW-1:0];

   // Pattern byte for the channel under the sweep counter
   assign pix_led   = IDX_W'(addr_ff) >> 2;
   assign pix_color = addr_ff[1:0];
   assign active    = IDX_W'(rem_rsp.remainder);
   assign led_gap   = (pix_led >= active) ? (pix_led - active) : (active - pix_led);
   assign in_strip  = pix_led < IDX_W'(led_count);

   always_comb begin
      pix_value = '0;
      if (in_strip) begin
         unique case (mode_ff)
            MODE_BLUE: begin
               if (pix_color == COLOR_BLUE && led_gap <= BLUE_SPAN) begin
                  pix_value = blue_fade(led_gap[2:0]);
               end
            end
            MODE_RED: begin
               if (pix_color == COLOR_RED && rem_rsp.remainder < RED_ON) begin
                  pix_value = RED_LEVEL;
               end
            end
            MODE_YELLOW: begin
               if ((pix_color == COLOR_RED || pix_color == COLOR_GREEN) &&
                   rem_rsp.remainder < YELLOW_ON) begin
                  pix_value = YELLOW_LEVEL;
               end
            end
            MODE_WHITE: begin
               if (pix_color == COLOR_WHITE) begin
                  pix_value = WHITE_LEVEL;
               end
            end
            default: pix_value = '0;
         endcase
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (addr_ff == ADDR_LAST) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (opcode_type'(req_chan.opcode))
                  OP_TICK:     state_in = ST_DIV;
                  OP_READ:     state_in = ST_READ;
                  OP_SET_MODE: state_in = ST_DONE;
                  OP_WRITE:    state_in = ST_DONE;
               endcase
            end
         end
         ST_DIV: begin
            if (rem_rsp.done) state_in = ST_SWEEP;
         end
         ST_SWEEP: begin
            if (addr_ff == ADDR_LAST) state_in = ST_DONE;
         end
         ST_READ:  state_in = ST_DONE;
         ST_DONE: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      req_chan.ready   = 1'b0;
      finish           = 1'b0;
      ram_we           = 1'b0;
      ram_re           = 1'b0;
      ram_addr         = addr_ff;
      ram_wdata        = '0;
      rem_req.start    = 1'b0;
      rem_req.dividend = step_ff;
      unique case (mode_ff)
         MODE_RED:    rem_req.divisor = RED_PERIOD;
         MODE_YELLOW: rem_req.divisor = YELLOW_PERIOD;
         default:     rem_req.divisor = led_count;
      endcase
      unique case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
         end
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            rem_req.start  = accept && (opcode_type'(req_chan.opcode) == OP_TICK);
         end
         ST_SWEEP: begin
            ram_we    = 1'b1;
            ram_wdata = pix_value;
         end
         ST_READ: begin
            ram_re   = 1'b1;
            ram_addr = ch_addr;
         end
         ST_DONE: begin
            finish    = slot_free;
            ram_we    = slot_free && (op_ff == OP_WRITE) && ch_ok;
            ram_addr  = ch_addr;
            ram_wdata = val_ff;
         end
         default: ;
      endcase
   end

   // Latch the word; advance the sweep counter in clear and sweep, else zero it
   always_comb begin
      op_in   = op_ff;
      code_in = code_ff;
      ch_in   = ch_ff;
      val_in  = val_ff;
      addr_in = addr_ff;
      if (accept) begin
         op_in   = opcode_type'(req_chan.opcode);
         code_in = req_chan.mode_code;
         ch_in   = req_chan.channel_number;
         val_in  = req_chan.channel_value;
      end
      if (state_ff == ST_CLEAR || state_ff == ST_SWEEP) begin
         addr_in = addr_ff + AW'(1);
      end else begin
         addr_in = '0;
      end
   end

   // Mode, step and response word at the end of the item
   always_comb begin
      mode_in       = mode_ff;
      step_in       = step_ff;
      bad_in        = 1'b0;
      read_value_in = '0;
      unique case (op_ff)
         OP_TICK: begin
            step_in = (step_ff == STEP_LAST) ? '0 : step_ff + STEP_W'(1);
         end
         OP_SET_MODE: begin
            if (code_ff <= MODE_WHITE) begin
               mode_in = code_ff;
               step_in = '0;
            end else begin
               bad_in = 1'b1;
            end
         end
         OP_WRITE: begin
            mode_in = MODE_DARK;
            bad_in  = !ch_ok;
         end
         OP_READ: begin
            bad_in        = !ch_ok;
            read_value_in = ch_ok ? ram_rdata : '0;
         end
      endcase
   end

   // Hold the response until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (finish) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         addr_ff      <= '0;
         mode_ff      <= MODE_DARK;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (finish) begin
            mode_ff <= mode_in;
            step_ff <= step_in;
         end
      end
      op_ff   <= op_in;
      code_ff <= code_in;
      ch_ff   <= ch_in;
      val_ff  <= val_in;
      if (finish) begin
         read_value_ff <= read_value_in;
         bad_ff        <= bad_in;
         mode_now_ff   <= mode_in;
         step_now_ff   <= step_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.read_value  = read_value_ff;
   assign rsp_chan.bad_request = bad_ff;
   assign rsp_chan.mode_now    = mode_now_ff;
   assign rsp_chan.step_now    = step_now_ff;

   // Checks on sequencer and state
   `LSPCS_ASSERT_IMPLY(a_step_range, clock, reset, 1'b1, step_ff <= STEP_LAST)
   `LSPCS_ASSERT_IMPLY(a_mode_range, clock, reset, 1'b1, mode_ff <= MODE_WHITE)
   `LSPCS_ASSERT_IMPLY(a_sweep_after_div, clock, reset, state_ff == ST_SWEEP, !rem_rsp.busy)
   `LSPCS_ASSERT_NEXT(a_done_loads_rsp, clock, reset, finish, rsp_valid_ff && state_ff == ST_IDLE)

endmodule

FILE: hw/rtl/lspcs_ram.sv
// ----------------------------------------------------------------------------
// lspcs_ram
// Single-port RAM with registered read; read data holds until the next read.
// ----------------------------------------------------------------------------
module lspcs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write and registered read on one port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: hw/rtl/lspcs_rem.sv
// ----------------------------------------------------------------------------
// lspcs_rem
// Restoring remainder unit: step counter modulo a byte divisor, one bit a
// cycle.
// ----------------------------------------------------------------------------
module lspcs_rem (
   input  logic                   clock,
   input  logic                   reset,
   input  lspcs_pkg::rem_req_type req,
   output lspcs_pkg::rem_rsp_type rsp
);
   import lspcs_pkg::*;

   logic                 busy_ff, busy_in;
   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic [STEP_W-1:0]    dividend_ff, dividend_in;
   logic [LED_W-1:0]     divisor_ff, divisor_in;
   logic [LED_W-1:0]     rem_ff, rem_in;
   logic [LED_W:0]       trial;
   logic [LED_W:0]       diff;
   logic                 fits;
   logic                 last;

   // Shift in the next dividend bit and try the subtraction
   assign trial = {rem_ff, dividend_ff[STEP_W-1]};
   assign diff  = trial - {1'b0, divisor_ff};
   assign fits  = trial >= {1'b0, divisor_ff};
   assign last  = busy_ff && (count_ff == DIV_CNT_W'(DIV_STEPS - 1));

   // Sequence the iterations
   always_comb begin
      busy_in     = busy_ff;
      count_in    = count_ff;
      dividend_in = dividend_ff;
      divisor_in  = divisor_ff;
      rem_in      = rem_ff;
      if (req.start) begin
         busy_in     = 1'b1;
         count_in    = '0;
         dividend_in = req.dividend;
         divisor_in  = req.divisor;
         rem_in      = '0;
      end else if (busy_ff) begin
         count_in    = count_ff + DIV_CNT_W'(1);
         dividend_in = {dividend_ff[STEP_W-2:0], 1'b0};
         rem_in      = fits ? diff[LED_W-1:0] : trial[LED_W-1:0];
         if (last) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
      dividend_ff <= dividend_in;
      divisor_ff  <= divisor_in;
      rem_ff      <= rem_in;
   end

   assign rsp.busy      = busy_ff;
   assign rsp.done      = last;
   assign rsp.remainder = rem_ff;

endmodule

FILE: hw/rtl/lspcs_csr.sv
// ----------------------------------------------------------------------------
// lspcs_csr
// APB register file: holds the LED count painted by the patterns.
// ----------------------------------------------------------------------------
module lspcs_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [lspcs_pkg::APB_ADDR_W-1:0]      paddr,
   input  logic [lspcs_pkg::APB_DATA_W-1:0]      pwdata,
   output logic [lspcs_pkg::APB_DATA_W-1:0]      prdata,
   output logic                                  pready,
   output logic [lspcs_pkg::LED_W-1:0]           led_count
);
   import lspcs_pkg::*;

   logic [LED_W-1:0] led_count_ff, led_count_in;
   logic             hit;

   assign hit = (paddr[APB_ADDR_W-1:2] == REG_LED_COUNT);

   // Take the write in the access phase
   always_comb begin
      led_count_in = led_count_ff;
      if (psel && penable && pwrite && hit) begin
         led_count_in = pwdata[LED_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         led_count_ff <= LED_COUNT_RST;
      end else begin
         led_count_ff <= led_count_in;
      end
   end

   assign prdata    = hit ? APB_DATA_W'(led_count_ff) : '0;
   assign pready    = 1'b1;
   assign led_count = led_count_ff;

endmodule
